@@ rtl/core/tick_task_release_scheduler_core_defines.svh @@
// ----------------------------------------------------------------------------
// Tick task release scheduler assertion macros
// Concurrent assertion shorthands for same-cycle and next-cycle implications
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH
`define TICK_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define TTRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ttrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler package
// Sizes, codes, handshake structs and name compare helpers
// ----------------------------------------------------------------------------
`default_nettype none

package ttrs_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int NAME_BYTES = 8;

   localparam int MODE_W   = 4;
   localparam int SLOT_W   = 4;
   localparam int NAME_W   = 64;
   localparam int PERIOD_W = 16;
   localparam int PRIO_W   = 8;
   localparam int START_W  = 2;
   localparam int CODE_W   = 2;
   localparam int RT_W     = 5;
   localparam int TICK_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int IDX_W     = $clog2(TASK_SLOTS);
   localparam int CNT_W     = $clog2(TASK_SLOTS + 1);
   localparam int DIV_STEPS = PERIOD_W;
   localparam int RUN_STEPS = (TASK_SLOTS > DIV_STEPS) ? TASK_SLOTS : DIV_STEPS;
   localparam int STEP_W    = $clog2(RUN_STEPS);

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE   = 4'd0,
      MODE_DELETE   = 4'd1,
      MODE_ENABLE   = 4'd2,
      MODE_DISABLE  = 4'd3,
      MODE_FORCE    = 4'd4,
      MODE_RESTART  = 4'd5,
      MODE_PERIOD   = 4'd6,
      MODE_FIND     = 4'd7,
      MODE_ENALL    = 4'd8,
      MODE_DISALL   = 4'd9,
      MODE_TICK     = 4'd10,
      MODE_DISPATCH = 4'd11,
      MODE_DONE     = 4'd12
   } mode_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_DISABLED = 2'd1,
      ST_ENABLED  = 2'd2,
      ST_READY    = 2'd3
   } status_type;

   typedef enum logic [CODE_W-1:0] {
      RC_OK         = 2'd0,
      RC_REJECT     = 2'd1,
      RC_MISSING    = 2'd2,
      RC_NONE_READY = 2'd3
   } result_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_LEN = 2'd0,
      CSR_POLICY   = 2'd1,
      CSR_RUNNING  = 2'd2
   } csr_index_type;

   localparam logic [START_W-1:0] START_ON = 2'd1;

   typedef struct packed {
      logic load;
      logic step;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_step;
   } dp_status_type;

   function automatic logic [NAME_W-1:0] name_mask();
      logic [NAME_W-1:0] m;
      m = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         m[8*i +: 8] = 8'hff;
      end
      return m;
   endfunction

   function automatic logic names_equal(input logic [NAME_W-1:0] a,
                                        input logic [NAME_W-1:0] b);
      logic eq;
      logic stop;
      eq   = 1'b1;
      stop = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (!stop) begin
            if (a[8*i +: 8] != b[8*i +: 8]) begin
               eq   = 1'b0;
               stop = 1'b1;
            end else if (a[8*i +: 8] == 8'd0) begin
               stop = 1'b1;
            end
         end
      end
      return eq;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ttrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler controller
// Sequences load, slot walk, apply and result strobe for one command
// ----------------------------------------------------------------------------
`default_nettype none

module ttrs_ctrl
   import ttrs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd,
   input  wire dp_status_type dp_status
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_APPLY = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            if (dp_status.last_step) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ttrs_datapath.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler datapath
// Task table, serial slot walk, shift-subtract period divider and result regs
// ----------------------------------------------------------------------------
`default_nettype none

module ttrs_datapath
   import ttrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              dp_status,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [NAME_W-1:0]     req_name_key,
   input  wire logic [PERIOD_W-1:0]   req_period_ms,
   input  wire logic [PRIO_W-1:0]     req_priority_req,
   input  wire logic [START_W-1:0]    req_start_enabled,
   input  wire logic                  cfg_write,
   input  wire logic [CSR_IDX_W-1:0]  cfg_index,
   input  wire logic [CSR_DATA_W-1:0] cfg_data,
   output logic [CODE_W-1:0]          rsp_result_code,
   output logic [SLOT_W-1:0]          rsp_result_slot,
   output logic [RT_W-1:0]            rsp_ready_tasks
);

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
      return (int'(v) == TASK_SLOTS - 1) ? '0 : v + 1'b1;
   endfunction

   // configuration
   logic [TICK_W-1:0] tick_len_ff;
   logic              policy_ff;
   logic              running_ff;

   // latched command
   logic [MODE_W-1:0]   mode_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [NAME_W-1:0]   key_ff;
   logic [PERIOD_W-1:0] pms_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [START_W-1:0]  start_ff;

   // task table
   status_type          status_ff [TASK_SLOTS];
   logic [PERIOD_W-1:0] count_ff  [TASK_SLOTS];
   logic [PERIOD_W-1:0] period_ff [TASK_SLOTS];
   logic [PRIO_W-1:0]   tprio_ff  [TASK_SLOTS];
   logic [NAME_W-1:0]   name_ff   [TASK_SLOTS];

   logic [CNT_W-1:0] ready_total_ff, ready_total_in;
   logic [CNT_W-1:0] used_total_ff, used_total_in;
   logic [IDX_W-1:0] last_served_ff, last_served_in;

   // walk and scan
   logic [STEP_W-1:0] step_ff;
   logic [IDX_W-1:0]  widx_ff, widx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [PRIO_W-1:0] best_ff, best_in;
   logic              empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]  empty_idx_ff, empty_idx_in;

   // divider
   logic [TICK_W:0]     rem_ff;
   logic [PERIOD_W-1:0] quo_ff;
   logic [TICK_W:0]     div_trial;
   logic [TICK_W-1:0]   tl;

   // response
   result_type       code_ff, code_in;
   logic [IDX_W-1:0] rslot_ff, rslot_in;
   logic [CNT_W-1:0] rtasks_ff;

   // table access
   logic                walk_on;
   logic                div_on;
   logic [IDX_W-1:0]    s_idx;
   logic                slot_ok;
   logic [IDX_W-1:0]    addr;
   status_type          st_rd;
   logic [PERIOD_W-1:0] cnt_rd;
   logic [PERIOD_W-1:0] per_rd;
   logic [PRIO_W-1:0]   pr_rd;
   logic [NAME_W-1:0]   nm_rd;
   logic                name_hit;

   logic                st_we;
   status_type          st_wd;
   logic                cnt_we;
   logic [PERIOD_W-1:0] cnt_wd;
   logic                per_we;
   logic [PERIOD_W-1:0] per_wd;
   logic                ent_we;

   assign tl        = (tick_len_ff == '0) ? TICK_W'(1) : tick_len_ff;
   assign walk_on   = int'(step_ff) < TASK_SLOTS;
   assign div_on    = int'(step_ff) < DIV_STEPS;
   assign dp_status.last_step = int'(step_ff) == RUN_STEPS - 1;
   assign div_trial = {rem_ff[TICK_W-1:0], quo_ff[PERIOD_W-1]};

   assign slot_ok = int'(slot_ff) < TASK_SLOTS;
   assign s_idx   = slot_ok ? IDX_W'(slot_ff) : '0;
   assign addr    = !cmd.apply ? widx_ff :
                    (mode_ff == MODE_CREATE) ? empty_idx_ff : s_idx;

   assign st_rd    = status_ff[addr];
   assign cnt_rd   = count_ff[addr];
   assign per_rd   = period_ff[addr];
   assign pr_rd    = tprio_ff[addr];
   assign nm_rd    = name_ff[addr];
   assign name_hit = (st_rd != ST_EMPTY) && names_equal(key_ff, nm_rd);

   always_comb begin
      st_we          = 1'b0;
      st_wd          = st_rd;
      cnt_we         = 1'b0;
      cnt_wd         = cnt_rd;
      per_we         = 1'b0;
      per_wd         = quo_ff;
      ent_we         = 1'b0;
      ready_total_in = ready_total_ff;
      used_total_in  = used_total_ff;
      last_served_in = last_served_ff;
      widx_in        = widx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      best_in        = best_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      code_in        = code_ff;
      rslot_in       = rslot_ff;

      if (cmd.load) begin
         widx_in        = ((req_mode == MODE_DISPATCH) && !policy_ff) ?
                          wrap_inc(last_served_ff) : '0;
         hit_in         = 1'b0;
         empty_found_in = 1'b0;
      end

      if (cmd.step && walk_on) begin
         widx_in = wrap_inc(widx_ff);
         case (mode_ff)
            MODE_CREATE: begin
               if (name_hit) begin
                  hit_in = 1'b1;
               end
               if ((st_rd == ST_EMPTY) && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = widx_ff;
               end
            end
            MODE_FIND: begin
               if (name_hit && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = widx_ff;
               end
            end
            MODE_TICK: begin
               if (running_ff && (st_rd == ST_ENABLED)) begin
                  cnt_we = 1'b1;
                  if (cnt_rd > per_rd) begin
                     cnt_wd         = '0;
                     st_we          = 1'b1;
                     st_wd          = ST_READY;
                     ready_total_in = ready_total_ff + 1'b1;
                  end else begin
                     cnt_wd = cnt_rd + 1'b1;
                  end
               end
            end
            MODE_ENALL: begin
               if (st_rd == ST_DISABLED) begin
                  st_we = 1'b1;
                  st_wd = ST_ENABLED;
               end
            end
            MODE_DISALL: begin
               if (st_rd != ST_EMPTY) begin
                  st_we = 1'b1;
                  st_wd = ST_DISABLED;
                  if (st_rd == ST_READY) begin
                     ready_total_in = ready_total_ff - 1'b1;
                  end
               end
            end
            MODE_DISPATCH: begin
               if (st_rd == ST_READY) begin
                  if (!hit_ff || (policy_ff && (pr_rd < best_ff))) begin
                     hit_in     = 1'b1;
                     hit_idx_in = widx_ff;
                     best_in    = pr_rd;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.apply) begin
         code_in  = RC_OK;
         rslot_in = '0;
         if ((mode_ff inside {[MODE_DELETE:MODE_PERIOD], MODE_DONE}) &&
             !(slot_ok && (st_rd != ST_EMPTY))) begin
            code_in = RC_MISSING;
         end else begin
            case (mode_ff)
               MODE_CREATE: begin
                  if (hit_ff || (used_total_ff >= CNT_W'(TASK_SLOTS)) ||
                      (start_ff > START_ON) || !empty_found_ff) begin
                     code_in = RC_REJECT;
                  end else begin
                     ent_we        = 1'b1;
                     st_we         = 1'b1;
                     st_wd         = (start_ff == START_ON) ? ST_ENABLED : ST_DISABLED;
                     per_we        = 1'b1;
                     per_wd        = (pms_ff <= PERIOD_W'(tl)) ? PERIOD_W'(tl) : quo_ff;
                     cnt_we        = 1'b1;
                     cnt_wd        = '0;
                     used_total_in = used_total_ff + 1'b1;
                     rslot_in      = empty_idx_ff;
                  end
               end
               MODE_DELETE: begin
                  if (st_rd == ST_READY) begin
                     ready_total_in = ready_total_ff - 1'b1;
                  end
                  st_we = 1'b1;
                  st_wd = ST_EMPTY;
                  if (used_total_ff != '0) begin
                     used_total_in = used_total_ff - 1'b1;
                  end
               end
               MODE_ENABLE: begin
                  if (st_rd == ST_DISABLED) begin
                     st_we = 1'b1;
                     st_wd = ST_ENABLED;
                  end
               end
               MODE_DISABLE: begin
                  if (st_rd == ST_READY) begin
                     ready_total_in = ready_total_ff - 1'b1;
                  end
                  st_we = 1'b1;
                  st_wd = ST_DISABLED;
               end
               MODE_FORCE: begin
                  if (st_rd == ST_ENABLED) begin
                     st_we          = 1'b1;
                     st_wd          = ST_READY;
                     cnt_we         = 1'b1;
                     cnt_wd         = per_rd;
                     ready_total_in = ready_total_ff + 1'b1;
                  end
               end
               MODE_RESTART: begin
                  if ((st_rd == ST_ENABLED) || (st_rd == ST_READY)) begin
                     if (st_rd == ST_READY) begin
                        ready_total_in = ready_total_ff - 1'b1;
                     end
                     st_we  = 1'b1;
                     st_wd  = ST_ENABLED;
                     cnt_we = 1'b1;
                     cnt_wd = per_rd;
                  end
               end
               MODE_PERIOD: begin
                  per_we = 1'b1;
                  per_wd = quo_ff;
                  if (st_rd == ST_READY) begin
                     ready_total_in = ready_total_ff - 1'b1;
                     st_we          = 1'b1;
                     st_wd          = ST_ENABLED;
                     cnt_we         = 1'b1;
                     cnt_wd         = quo_ff;
                  end
               end
               MODE_FIND: begin
                  if (hit_ff) begin
                     rslot_in = hit_idx_ff;
                  end else begin
                     code_in = RC_MISSING;
                  end
               end
               MODE_ENALL, MODE_DISALL, MODE_TICK: begin
               end
               MODE_DISPATCH: begin
                  if (hit_ff) begin
                     last_served_in = hit_idx_ff;
                     rslot_in       = hit_idx_ff;
                  end else begin
                     code_in = RC_NONE_READY;
                  end
               end
               MODE_DONE: begin
                  if ((st_rd == ST_READY) && (cnt_rd == '0)) begin
                     ready_total_in = ready_total_ff - 1'b1;
                     st_we          = 1'b1;
                     st_wd          = ST_ENABLED;
                  end
               end
               default: begin
                  code_in = RC_REJECT;
               end
            endcase
         end
      end
   end

   // control and reset-cleared state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff    <= TICK_W'(1);
         policy_ff      <= 1'b0;
         running_ff     <= 1'b0;
         ready_total_ff <= '0;
         used_total_ff  <= '0;
         last_served_ff <= '0;
         step_ff        <= '0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            status_ff[i] <= ST_EMPTY;
            count_ff[i]  <= '0;
         end
      end else begin
         if (cfg_write) begin
            case (cfg_index)
               CSR_TICK_LEN: tick_len_ff <= cfg_data;
               CSR_POLICY:   policy_ff   <= cfg_data[0];
               CSR_RUNNING:  running_ff  <= cfg_data[0];
               default: begin
               end
            endcase
         end
         ready_total_ff <= ready_total_in;
         used_total_ff  <= used_total_in;
         last_served_ff <= last_served_in;
         if (cmd.load) begin
            step_ff <= '0;
         end else if (cmd.step) begin
            step_ff <= step_ff + 1'b1;
         end
         if (st_we) begin
            status_ff[addr] <= st_wd;
         end
         if (cnt_we) begin
            count_ff[addr] <= cnt_wd;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         slot_ff  <= req_slot;
         key_ff   <= req_name_key & name_mask();
         pms_ff   <= req_period_ms;
         prio_ff  <= req_priority_req;
         start_ff <= req_start_enabled;
         rem_ff   <= '0;
         quo_ff   <= req_period_ms;
      end else if (cmd.step && div_on) begin
         if (div_trial >= {1'b0, tl}) begin
            rem_ff <= div_trial - {1'b0, tl};
            quo_ff <= {quo_ff[PERIOD_W-2:0], 1'b1};
         end else begin
            rem_ff <= div_trial;
            quo_ff <= {quo_ff[PERIOD_W-2:0], 1'b0};
         end
      end
      widx_ff        <= widx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      best_ff        <= best_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      if (per_we) begin
         period_ff[addr] <= per_wd;
      end
      if (ent_we) begin
         tprio_ff[addr] <= prio_ff;
         name_ff[addr]  <= key_ff;
      end
      if (cmd.apply) begin
         code_ff   <= code_in;
         rslot_ff  <= rslot_in;
         rtasks_ff <= ready_total_in;
      end
   end

   assign rsp_result_code = code_ff;
   assign rsp_result_slot = SLOT_W'(rslot_ff);
   assign rsp_ready_tasks = RT_W'(rtasks_ff);

endmodule

`default_nettype wire

@@ rtl/core/tick_task_release_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler core
// Periodic task table with tick release, dispatch and name lookup
//
//   channel  ports                                    transfer when
//   req      start, busy, req_*                       start && !busy
//   rsp      rsp_valid, rsp_*                         rsp_valid (no stall)
//   csr      csr_valid, csr_ready, csr_index/data     csr_valid && csr_ready
//
// every command passes through the transfer cycle that loads it, a 16-step
// slot walk that also runs the shift-subtract period divider, an apply state
// and the strobe state; start is taken again the cycle after the strobe.
// reset is synchronous and clears the table to empty, counters to zero.
// results cannot be stalled; csr writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_task_release_scheduler_core
   import ttrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [NAME_W-1:0]     req_name_key,
   input  wire logic [PERIOD_W-1:0]   req_period_ms,
   input  wire logic [PRIO_W-1:0]     req_priority_req,
   input  wire logic [START_W-1:0]    req_start_enabled,
   output logic                       rsp_valid,
   output logic [CODE_W-1:0]          rsp_result_code,
   output logic [SLOT_W-1:0]          rsp_result_slot,
   output logic [RT_W-1:0]            rsp_ready_tasks,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   ttrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   ttrs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .req_mode          (req_mode),
      .req_slot          (req_slot),
      .req_name_key      (req_name_key),
      .req_period_ms     (req_period_ms),
      .req_priority_req  (req_priority_req),
      .req_start_enabled (req_start_enabled),
      .cfg_write         (csr_valid && csr_ready),
      .cfg_index         (csr_index),
      .cfg_data          (csr_data),
      .rsp_result_code   (rsp_result_code),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_ready_tasks   (rsp_ready_tasks)
   );

endmodule

`default_nettype wire

@@ rtl/core/ttrs_checker.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler port checker
// Command and result sequencing seen at the core boundary
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_task_release_scheduler_core_defines.svh"

module ttrs_checker
   import ttrs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic [MODE_W-1:0]     req_mode,
   input wire logic [SLOT_W-1:0]     req_slot,
   input wire logic [NAME_W-1:0]     req_name_key,
   input wire logic [PERIOD_W-1:0]   req_period_ms,
   input wire logic [PRIO_W-1:0]     req_priority_req,
   input wire logic [START_W-1:0]    req_start_enabled,
   input wire logic                  rsp_valid,
   input wire logic [CODE_W-1:0]     rsp_result_code,
   input wire logic [SLOT_W-1:0]     rsp_result_slot,
   input wire logic [RT_W-1:0]       rsp_ready_tasks,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_data
);

   `TTRS_ASSERT_NEXT(a_busy_after_transfer, clock, reset, start && !busy, busy,
      "busy low after transfer")
   `TTRS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy,
      "result strobe not single")
   `TTRS_ASSERT_SAME(a_strobe_while_busy, clock, reset, rsp_valid, busy,
      "result outside a command")
   `TTRS_ASSERT_SAME(a_none_ready_slot, clock, reset,
      rsp_valid && (rsp_result_code == RC_NONE_READY), rsp_result_slot == '0,
      "slot set with no ready task")

endmodule

bind tick_task_release_scheduler_core ttrs_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/ttrs_sched_checker.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler checker
// Watches the command, result and register channels, keeps its own copy of
// the task table, predicts the answer of every accepted command and compares
// each result against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module ttrs_sched_checker
   import ttrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [NAME_W-1:0]     req_name_key,
   input  wire logic [PERIOD_W-1:0]   req_period_ms,
   input  wire logic [PRIO_W-1:0]     req_priority_req,
   input  wire logic [START_W-1:0]    req_start_enabled,
   input  wire logic                  rsp_valid,
   input  wire logic [CODE_W-1:0]     rsp_result_code,
   input  wire logic [SLOT_W-1:0]     rsp_result_slot,
   input  wire logic [RT_W-1:0]       rsp_ready_tasks,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [SLOT_W-1:0] slot;
      logic [RT_W-1:0]   ready;
   } sched_answer_t;

   status_type            tab_status [TASK_SLOTS];
   logic [PERIOD_W-1:0]   tab_period [TASK_SLOTS];
   logic [PERIOD_W-1:0]   tab_count  [TASK_SLOTS];
   logic [PRIO_W-1:0]     tab_prio   [TASK_SLOTS];
   logic [NAME_W-1:0]     tab_name   [TASK_SLOTS];
   int                    ready_cnt;
   int                    used_cnt;
   logic [SLOT_W-1:0]     last_served;
   logic [TICK_W-1:0]     tick_len;
   logic                  policy_best;
   logic                  running;
   sched_answer_t         answer_q [$];

   // names match byte by byte and stop at a shared zero byte
   function automatic bit same_name(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
         if (a[8*i +: 8] == 8'd0) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic void drop_ready(int s);
      if (tab_status[s] == ST_READY && ready_cnt > 0) ready_cnt--;
   endfunction

   function automatic sched_answer_t run_command(logic [MODE_W-1:0] mode,
         logic [SLOT_W-1:0] s, logic [NAME_W-1:0] key, logic [PERIOD_W-1:0] pms,
         logic [PRIO_W-1:0] prio, logic [START_W-1:0] st);
      sched_answer_t r;
      int tl;
      int pick;
      int c;
      bit bad;
      bit found;
      r = '0;
      tl = (tick_len == 0) ? 1 : int'(tick_len);
      if (((mode >= MODE_DELETE && mode <= MODE_PERIOD) || mode == MODE_DONE)
            && tab_status[s] == ST_EMPTY) begin
         r.code = RC_MISSING;
      end else begin
         case (mode)
            MODE_CREATE: begin
               bad = (used_cnt >= TASK_SLOTS) || (st > START_ON);
               for (int i = 0; i < TASK_SLOTS; i++)
                  if (tab_status[i] != ST_EMPTY && same_name(key, tab_name[i])) bad = 1'b1;
               pick = -1;
               for (int i = TASK_SLOTS - 1; i >= 0; i--)
                  if (tab_status[i] == ST_EMPTY) pick = i;
               if (bad || pick < 0) begin
                  r.code = RC_REJECT;
               end else begin
                  tab_name[pick]   = key;
                  tab_status[pick] = (st == START_ON) ? ST_ENABLED : ST_DISABLED;
                  tab_period[pick] = PERIOD_W'((int'(pms) <= tl) ? tl : int'(pms) / tl);
                  tab_prio[pick]   = prio;
                  tab_count[pick]  = '0;
                  used_cnt++;
                  r.slot = SLOT_W'(pick);
               end
            end
            MODE_DELETE: begin
               drop_ready(s);
               tab_status[s] = ST_EMPTY;
               if (used_cnt > 0) used_cnt--;
            end
            MODE_ENABLE:
               if (tab_status[s] == ST_DISABLED) tab_status[s] = ST_ENABLED;
            MODE_DISABLE: begin
               drop_ready(s);
               tab_status[s] = ST_DISABLED;
            end
            MODE_FORCE:
               if (tab_status[s] == ST_ENABLED) begin
                  tab_status[s] = ST_READY;
                  tab_count[s] = tab_period[s];
                  ready_cnt++;
               end
            MODE_RESTART:
               if (tab_status[s] == ST_ENABLED || tab_status[s] == ST_READY) begin
                  drop_ready(s);
                  tab_status[s] = ST_ENABLED;
                  tab_count[s] = tab_period[s];
               end
            MODE_PERIOD: begin
               tab_period[s] = PERIOD_W'(int'(pms) / tl);
               if (tab_status[s] == ST_READY) begin
                  drop_ready(s);
                  tab_status[s] = ST_ENABLED;
                  tab_count[s] = tab_period[s];
               end
            end
            MODE_FIND: begin
               r.code = RC_MISSING;
               for (int i = TASK_SLOTS - 1; i >= 0; i--)
                  if (tab_status[i] != ST_EMPTY && same_name(key, tab_name[i])) begin
                     r.code = RC_OK;
                     r.slot = SLOT_W'(i);
                  end
            end
            MODE_ENALL:
               for (int i = 0; i < TASK_SLOTS; i++)
                  if (tab_status[i] == ST_DISABLED) tab_status[i] = ST_ENABLED;
            MODE_DISALL:
               for (int i = 0; i < TASK_SLOTS; i++)
                  if (tab_status[i] != ST_EMPTY) begin
                     drop_ready(i);
                     tab_status[i] = ST_DISABLED;
                  end
            MODE_TICK:
               if (running)
                  for (int i = 0; i < TASK_SLOTS; i++)
                     if (tab_status[i] == ST_ENABLED) begin
                        if (tab_count[i] > tab_period[i]) begin
                           tab_count[i] = '0;
                           tab_status[i] = ST_READY;
                           ready_cnt++;
                        end else begin
                           tab_count[i] = tab_count[i] + 1'b1;
                        end
                     end
            MODE_DISPATCH: begin
               found = 1'b0;
               pick = 0;
               if (!policy_best) begin
                  for (int i = 1; i <= TASK_SLOTS && !found; i++) begin
                     c = (int'(last_served) + i) % TASK_SLOTS;
                     if (tab_status[c] == ST_READY) begin
                        pick = c;
                        found = 1'b1;
                     end
                  end
               end else begin
                  for (int i = 0; i < TASK_SLOTS; i++)
                     if (tab_status[i] == ST_READY &&
                           (!found || tab_prio[i] < tab_prio[pick])) begin
                        pick = i;
                        found = 1'b1;
                     end
               end
               if (!found) begin
                  r.code = RC_NONE_READY;
               end else begin
                  last_served = SLOT_W'(pick);
                  r.slot = SLOT_W'(pick);
               end
            end
            MODE_DONE:
               if (tab_status[s] == ST_READY && tab_count[s] == 0) begin
                  drop_ready(s);
                  tab_status[s] = ST_ENABLED;
               end
            default: r.code = RC_REJECT;
         endcase
      end
      r.ready = RT_W'(ready_cnt);
      return r;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   sched_answer_t want;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            tab_status[i] = ST_EMPTY;
            tab_count[i] = '0;
         end
         ready_cnt = 0;
         used_cnt = 0;
         last_served = '0;
         tick_len = 8'd1;
         policy_best = 1'b0;
         running = 1'b0;
         answer_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            case (csr_index)
               CSR_TICK_LEN: tick_len = csr_data;
               CSR_POLICY:   policy_best = csr_data[0];
               CSR_RUNNING:  running = csr_data[0];
               default: ;
            endcase
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report("result with no command outstanding", rsp_result_code, -1);
            end else begin
               want = answer_q.pop_front();
               if (rsp_result_code !== want.code)
                  report("result_code", rsp_result_code, want.code);
               if (rsp_result_slot !== want.slot)
                  report("result_slot", rsp_result_slot, want.slot);
               if (rsp_ready_tasks !== want.ready)
                  report("ready_tasks", rsp_ready_tasks, want.ready);
            end
         end
         if (start && !busy)
            answer_q.push_back(run_command(req_mode, req_slot, req_name_key, req_period_ms,
                                           req_priority_req, req_start_enabled));
      end
      pending = answer_q.size();
   end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Tick task release scheduler testbench
// Directed commands, then random commands, some of them malformed, over several
// register settings with random sender gaps; a checker beside the core
// predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import ttrs_pkg::*;

   localparam int LIMIT = 600000;
   localparam logic [MODE_W-1:0] MODE_BAD = 4'd15;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [MODE_W-1:0]     req_mode;
   logic [SLOT_W-1:0]     req_slot;
   logic [NAME_W-1:0]     req_name_key;
   logic [PERIOD_W-1:0]   req_period_ms;
   logic [PRIO_W-1:0]     req_priority_req;
   logic [START_W-1:0]    req_start_enabled;
   logic                  rsp_valid;
   logic [CODE_W-1:0]     rsp_result_code;
   logic [SLOT_W-1:0]     rsp_result_slot;
   logic [RT_W-1:0]       rsp_ready_tasks;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;
   int                    cycles;
   logic [SLOT_W-1:0]     last_answer_slot;
   int                    cur_tick;
   logic [NAME_W-1:0]     names [8];

   tick_task_release_scheduler_core u_dut (.*);

   ttrs_sched_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid) last_answer_slot <= rsp_result_slot;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic issue(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                        input logic [NAME_W-1:0] k, input logic [PERIOD_W-1:0] p,
                        input logic [PRIO_W-1:0] pr, input logic [START_W-1:0] se);
      req_mode = m;
      req_slot = s;
      req_name_key = k;
      req_period_ms = p;
      req_priority_req = pr;
      req_start_enabled = se;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_index = idx;
      csr_data = d;
      csr_valid = 1'b1;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain;
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic setup(input logic [7:0] tl, input logic pol, input logic run);
      write_reg(CSR_TICK_LEN, tl);
      write_reg(CSR_POLICY, {7'd0, pol});
      write_reg(CSR_RUNNING, {7'd0, run});
      cur_tick = (tl == 0) ? 1 : tl;
   endtask

   task automatic random_command;
      logic [MODE_W-1:0] m;
      logic [SLOT_W-1:0] s;
      logic [NAME_W-1:0] k;
      logic [PERIOD_W-1:0] p;
      logic [PRIO_W-1:0] pr;
      logic [START_W-1:0] se;
      int w;
      w = $urandom_range(0, 99);
      if (w < 18)      m = MODE_CREATE;
      else if (w < 40) m = MODE_TICK;
      else if (w < 52) m = MODE_DISPATCH;
      else if (w < 62) m = MODE_DONE;
      else if (w < 69) m = MODE_FIND;
      else if (w < 74) m = MODE_DELETE;
      else if (w < 77) m = MODE_ENABLE;
      else if (w < 80) m = MODE_DISABLE;
      else if (w < 85) m = MODE_FORCE;
      else if (w < 88) m = MODE_RESTART;
      else if (w < 92) m = MODE_PERIOD;
      else if (w < 94) m = MODE_ENALL;
      else if (w < 96) m = MODE_DISALL;
      else if (w < 98) m = MODE_BAD - MODE_W'($urandom_range(0, 2));
      else             m = MODE_TICK;
      s = (m == MODE_DONE && $urandom_range(0, 9) < 7) ? last_answer_slot
                                                      : SLOT_W'($urandom_range(0, 15));
      k = ($urandom_range(0, 9) < 8) ? names[$urandom_range(0, 7)]
                                     : {$urandom, $urandom};
      if ($urandom_range(0, 9) < 8)
         p = PERIOD_W'(cur_tick * $urandom_range(1, 6) + $urandom_range(0, cur_tick - 1));
      else
         p = PERIOD_W'($urandom);
      pr = PRIO_W'($urandom);
      se = ($urandom_range(0, 9) < 8) ? START_W'($urandom_range(0, 1))
                                      : START_W'($urandom_range(2, 3));
      issue(m, s, k, p, pr, se);
   endtask

   initial begin
      cycles = 0;
      last_answer_slot = '0;
      start = 1'b0;
      req_mode = MODE_TICK;
      req_slot = '0;
      req_name_key = '0;
      req_period_ms = '0;
      req_priority_req = '0;
      req_start_enabled = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TICK_LEN;
      csr_data = '0;
      names[0] = 64'h0000_0000_0041_4243;
      names[1] = 64'h0000_0000_0044_4546;
      names[2] = 64'h7700_0000_0000_4142;
      names[3] = 64'h1100_0000_0000_4142;
      names[4] = 64'hffff_ffff_ffff_ffff;
      names[5] = 64'h0000_0000_0000_0000;
      names[6] = 64'h8070_6050_4030_2010;
      names[7] = 64'h0102_0304_0506_0708;
      reset = 1'b1;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed
      setup(8'd1, 1'b0, 1'b1);
      issue(MODE_CREATE, 4'd0, names[0], 16'd0, 8'd255, 2'd1);
      issue(MODE_CREATE, 4'd0, names[0], 16'd9, 8'd1, 2'd1);
      issue(MODE_CREATE, 4'd0, names[1], 16'd9, 8'd1, 2'd2);
      issue(MODE_CREATE, 4'd0, names[2], 16'hffff, 8'd0, 2'd0);
      issue(MODE_CREATE, 4'd0, names[3], 16'd2, 8'd0, 2'd1);
      issue(MODE_FIND, 4'd0, names[2], 16'd0, 8'd0, 2'd0);
      issue(MODE_FIND, 4'd0, names[4], 16'd0, 8'd0, 2'd0);
      issue(MODE_ENABLE, 4'd1, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_FORCE, 4'd1, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_DISPATCH, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_RESTART, 4'd1, 64'd0, 16'd0, 8'd0, 2'd0);
      repeat (3) issue(MODE_TICK, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_DISPATCH, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_DONE, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_PERIOD, 4'd1, 64'd0, 16'hffff, 8'd0, 2'd0);
      issue(MODE_DISABLE, 4'd1, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_DISALL, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_DISPATCH, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_ENALL, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_DELETE, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_ENABLE, 4'd15, 64'd0, 16'd0, 8'd0, 2'd0);
      issue(MODE_BAD, 4'd0, 64'd0, 16'd0, 8'd0, 2'd0);
      drain();

      // random phases over register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: setup(8'd1, 1'b1, 1'b1);
            1: setup(8'd255, 1'b0, 1'b1);
            2: setup(8'd0, 1'b1, 1'b1);
            3: setup(8'd7, 1'b0, 1'b0);
            4: setup(8'($urandom_range(1, 255)), 1'b1, 1'b1);
            default: setup(8'd3, 1'b0, 1'b1);
         endcase
         for (int n = 0; n < 265; n++) begin
            random_command();
            if (n == 120) drain();
            if ((ph != 2 || n < 100) && $urandom_range(0, 99) < 38) begin
               start = 1'b0;
               repeat ($urandom_range(1, 24)) @(negedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/ttrs_pkg.sv
rtl/core/ttrs_ctrl.sv
rtl/core/ttrs_datapath.sv
rtl/core/tick_task_release_scheduler_core.sv
rtl/core/ttrs_checker.sv
tb/sv/ttrs_sched_checker.sv
tb/sv/testbench.sv
